### src/bft_pkg.sv
// shared constants, codes and controller/datapath interface types
package bft_pkg;

   // storage sizes
   localparam int PROGRAM_DEPTH = 128;
   localparam int TAPE_CELLS    = 64;
   localparam int INPUT_DEPTH   = 64;

   // derived widths
   localparam int PA_W = $clog2(PROGRAM_DEPTH);
   localparam int PC_W = $clog2(PROGRAM_DEPTH + 1);
   localparam int DP_W = $clog2(TAPE_CELLS);
   localparam int QA_W = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
   localparam int QC_W = $clog2(INPUT_DEPTH + 1);

   // fixed field widths
   localparam int LEN_W  = 8;
   localparam int ADDR_W = 7;
   localparam int BYTE_W = 8;

   // request kinds
   typedef enum logic [1:0] {
      OP_WRITE_PROG = 2'd0,
      OP_PUSH       = 2'd1,
      OP_RESTART    = 2'd2,
      OP_STEP       = 2'd3
   } op_type;

   // program instruction codes
   typedef enum logic [2:0] {
      I_RIGHT = 3'd0,
      I_LEFT  = 3'd1,
      I_INC   = 3'd2,
      I_DEC   = 3'd3,
      I_OUT   = 3'd4,
      I_IN    = 3'd5,
      I_OPEN  = 3'd6,
      I_CLOSE = 3'd7
   } instr_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic exec;
      logic scan;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic step_run;
      logic jump;
      logic scan_done;
   } status_type;

endpackage

### src/bft_datapath.sv
// tape machine datapath: program, tape and input memories, machine registers
module bft_datapath
   import bft_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [1:0]         req_opcode,
   input  logic [ADDR_W-1:0]  req_prog_address,
   input  logic [2:0]         req_instr_code,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               csr_write,
   input  logic [LEN_W-1:0]   csr_data,
   output logic               rsp_out_valid,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_halted,
   output logic               rsp_bracket_error,
   output logic [7:0]         rsp_pc_now
);

   // captured transaction
   op_type              op_ff;
   logic [ADDR_W-1:0]   addr_ff;
   instr_type           code_ff;
   logic [BYTE_W-1:0]   byte_ff;

   // memories
   instr_type           prog_mem [PROGRAM_DEPTH];
   logic [7:0]          tape_mem [TAPE_CELLS];
   logic [BYTE_W-1:0]   queue_mem [INPUT_DEPTH];
   logic [TAPE_CELLS-1:0] tape_vld_ff;
   instr_type           prog_rdata_ff;
   logic [7:0]          tape_rdata_ff;
   logic                cell_vld_ff;
   logic [BYTE_W-1:0]   queue_rdata_ff;
   logic [PA_W-1:0]     prog_raddr;

   // machine state
   logic [LEN_W-1:0]    len_ff;
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic [DP_W-1:0]     dp_ff, dp_in;
   logic [QC_W-1:0]     rd_ff, rd_in;
   logic [QC_W-1:0]     cnt_ff;
   logic                err_ff, err_in;

   // bracket scan
   logic [PA_W-1:0]     scan_ff, scan_in;
   logic [PC_W-1:0]     depth_ff, depth_in;
   logic                fwd_ff;

   // output instruction capture
   logic                emit_ff;
   logic [7:0]          emit_byte_ff;

   logic [PC_W-1:0]     eff_len;
   logic [7:0]          cur_cell;
   logic                run_ok;
   logic                jump;
   logic                match;
   logic                at_end;
   logic [PC_W-1:0]     scan_plus;

   // effective program length
   always_comb begin
      if (32'(len_ff) < PROGRAM_DEPTH) begin
         eff_len = PC_W'(len_ff);
      end else begin
         eff_len = PC_W'(PROGRAM_DEPTH);
      end
   end

   // the instruction at pc is in prog_rdata_ff during execute
   assign cur_cell = cell_vld_ff ? tape_rdata_ff : 8'd0;
   assign run_ok   = !err_ff && (pc_ff < eff_len);
   assign jump     = ((prog_rdata_ff == I_OPEN) && (cur_cell == 8'd0)) ||
                     ((prog_rdata_ff == I_CLOSE) && (cur_cell != 8'd0));

   // scan match and end tests on the entry just read
   assign scan_plus = PC_W'(scan_ff) + PC_W'(1);
   always_comb begin
      match    = 1'b0;
      depth_in = depth_ff;
      if (fwd_ff) begin
         if (prog_rdata_ff == I_OPEN) begin
            depth_in = depth_ff + PC_W'(1);
         end else if (prog_rdata_ff == I_CLOSE) begin
            depth_in = depth_ff - PC_W'(1);
            match    = (depth_ff == PC_W'(1));
         end
         at_end = (scan_plus >= eff_len);
         scan_in = scan_ff + PA_W'(1);
      end else begin
         if (prog_rdata_ff == I_CLOSE) begin
            depth_in = depth_ff + PC_W'(1);
         end else if (prog_rdata_ff == I_OPEN) begin
            depth_in = depth_ff - PC_W'(1);
            match    = (depth_ff == PC_W'(1));
         end
         at_end = (scan_ff == '0);
         scan_in = scan_ff - PA_W'(1);
      end
   end

   assign status.step_run  = (op_ff == OP_STEP) && run_ok;
   assign status.jump      = jump;
   assign status.scan_done = match || at_end;

   // program read address
   always_comb begin
      if (cmd.scan) begin
         prog_raddr = scan_in;
      end else begin
         prog_raddr = pc_ff[PA_W-1:0];
      end
   end

   // capture the request transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_opcode);
         addr_ff <= req_prog_address;
         code_ff <= instr_type'(req_instr_code);
         byte_ff <= req_data_byte;
      end
   end

   // program store: written by load transactions, read at pc or scan index
   always_ff @(posedge clock) begin
      if (cmd.decode && (op_ff == OP_WRITE_PROG)) begin
         prog_mem[PA_W'(addr_ff)] <= code_ff;
      end
      prog_rdata_ff <= prog_mem[prog_raddr];
   end

   // input queue
   always_ff @(posedge clock) begin
      if (cmd.decode && (op_ff == OP_PUSH) && (32'(cnt_ff) < INPUT_DEPTH)) begin
         queue_mem[cnt_ff[QA_W-1:0]] <= byte_ff;
      end
      queue_rdata_ff <= queue_mem[rd_ff[QA_W-1:0]];
   end

   // next machine state for an executed instruction
   always_comb begin
      pc_in  = pc_ff;
      dp_in  = dp_ff;
      rd_in  = rd_ff;
      err_in = err_ff;
      if (cmd.exec && !jump) begin
         pc_in = pc_ff + PC_W'(1);
         unique case (prog_rdata_ff)
            I_RIGHT: begin
               if (32'(dp_ff) + 1 < TAPE_CELLS) begin
                  dp_in = dp_ff + DP_W'(1);
               end
            end
            I_LEFT: begin
               if (dp_ff != '0) begin
                  dp_in = dp_ff - DP_W'(1);
               end
            end
            I_IN: begin
               if (32'(rd_ff) < INPUT_DEPTH) begin
                  rd_in = rd_ff + QC_W'(1);
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.scan) begin
         if (match) begin
            pc_in = scan_plus;
         end else if (at_end) begin
            err_in = 1'b1;
         end
      end
   end

   // tape memory with per-cell valid bits
   always_ff @(posedge clock) begin
      if (cmd.exec && !jump) begin
         unique case (prog_rdata_ff)
            I_INC: tape_mem[dp_ff] <= cur_cell + 8'd1;
            I_DEC: tape_mem[dp_ff] <= cur_cell - 8'd1;
            I_IN:  tape_mem[dp_ff] <= (rd_ff < cnt_ff) ? queue_rdata_ff : 8'd0;
            default: begin
            end
         endcase
      end
      tape_rdata_ff <= tape_mem[dp_ff];
      cell_vld_ff   <= tape_vld_ff[dp_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         pc_ff       <= '0;
         dp_ff       <= '0;
         rd_ff       <= '0;
         cnt_ff      <= '0;
         err_ff      <= 1'b0;
         tape_vld_ff <= '0;
      end else begin
         if (csr_write) begin
            len_ff <= csr_data;
         end
         if (cmd.decode && (op_ff == OP_RESTART)) begin
            pc_ff       <= '0;
            dp_ff       <= '0;
            rd_ff       <= '0;
            err_ff      <= 1'b0;
            tape_vld_ff <= '0;
         end else begin
            pc_ff  <= pc_in;
            dp_ff  <= dp_in;
            rd_ff  <= rd_in;
            err_ff <= err_in;
         end
         if (cmd.decode && (op_ff == OP_PUSH) && (32'(cnt_ff) < INPUT_DEPTH)) begin
            cnt_ff <= cnt_ff + QC_W'(1);
         end
         if (cmd.exec && !jump &&
             ((prog_rdata_ff == I_INC) || (prog_rdata_ff == I_DEC) ||
              (prog_rdata_ff == I_IN))) begin
            tape_vld_ff[dp_ff] <= 1'b1;
         end
      end
   end

   // scan registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         scan_ff  <= pc_ff[PA_W-1:0];
         depth_ff <= '0;
         fwd_ff   <= (prog_rdata_ff == I_OPEN);
      end else if (cmd.scan) begin
         scan_ff  <= scan_in;
         depth_ff <= depth_in;
      end
   end

   // output instruction result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         emit_ff <= 1'b0;
      end else if (cmd.exec && (prog_rdata_ff == I_OUT)) begin
         emit_ff      <= 1'b1;
         emit_byte_ff <= cur_cell;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_out_valid     <= emit_ff;
         rsp_out_byte      <= emit_ff ? emit_byte_ff : 8'd0;
         rsp_halted        <= err_ff || (pc_ff >= eff_len);
         rsp_bracket_error <= err_ff;
         rsp_pc_now        <= 8'(32'(pc_ff));
      end
   end

endmodule

### src/bft_control.sv
// tape machine controller: sequences decode, execute, scan and response
module bft_control
   import bft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_EXEC   = 5'b00100,
      S_SCAN   = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = status.step_run ? S_EXEC : S_RESP;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.jump ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/brainfuck_tape_machine.sv
// top level of the stepwise tape machine interpreter
//
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  opcode, prog_address, instr_code, data_byte
// rsp_      out        rsp_valid/rsp_ready  out_valid, out_byte, halted, bracket_error, pc_now
// csr_      in         csr_valid/csr_ready  csr_data (program length)
//
// program load, input push, restart and a step while halted go through accept, decode and response
// a running step goes through accept, decode with registered memory read, execute and response
// a taken bracket adds a scan of the program entries, read in turn on the program read port
// synchronous reset clears the tape valid bits at once, so no clearing pass is needed
// a new transaction is accepted while a finished response still waits on rsp_ready
module brainfuck_tape_machine
   import bft_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [ADDR_W-1:0]  req_prog_address,
   input  logic [2:0]         req_instr_code,
   input  logic [BYTE_W-1:0]  req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_out_valid,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_halted,
   output logic               rsp_bracket_error,
   output logic [7:0]         rsp_pc_now,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LEN_W-1:0]   csr_data
);

   cmd_type    cmd;
   status_type status;

   // register writes are taken in any cycle
   assign csr_ready = 1'b1;

   bft_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   bft_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_prog_address  (req_prog_address),
      .req_instr_code    (req_instr_code),
      .req_data_byte     (req_data_byte),
      .csr_write         (csr_valid),
      .csr_data          (csr_data),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_halted        (rsp_halted),
      .rsp_bracket_error (rsp_bracket_error),
      .rsp_pc_now        (rsp_pc_now)
   );

endmodule

### tb/brainfuck_tape_machine_test.sv
// self-checking testbench for the stepwise tape machine interpreter
module brainfuck_tape_machine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bft_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;

   // one predicted response transaction
   typedef struct packed {
      logic              out_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              halted;
      logic              bracket_error;
      logic [7:0]        pc_now;
   } step_status_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_opcode;
   logic [ADDR_W-1:0] req_prog_address;
   logic [2:0]        req_instr_code;
   logic [BYTE_W-1:0] req_data_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_out_valid;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_halted;
   logic              rsp_bracket_error;
   logic [7:0]        rsp_pc_now;
   logic              csr_valid;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_data;

   // machine state as the testbench tracks it
   instr_type         prog_codes [PROGRAM_DEPTH];
   logic [7:0]        tape_cells [TAPE_CELLS];
   logic [7:0]        in_bytes [INPUT_DEPTH];
   logic [DP_W-1:0]   dptr;
   logic [PC_W-1:0]   pc_reg;
   logic [QC_W-1:0]   in_count;
   logic [QC_W-1:0]   in_rd;
   logic              err_flag;
   logic [LEN_W-1:0]  prog_len;

   step_status_type   status_q [$];
   int                error_count = 0;
   int                checked_count = 0;
   int                items_sent = 0;
   int                idle_cycles = 0;
   bit                no_idle = 0;
   bit                hold_pending = 0;

   brainfuck_tape_machine i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_prog_address  (req_prog_address),
      .req_instr_code    (req_instr_code),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_halted        (rsp_halted),
      .rsp_bracket_error (rsp_bracket_error),
      .rsp_pc_now        (rsp_pc_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run state cleared by reset and by a restart
   function automatic void clear_run_state();
      for (int k = 0; k < TAPE_CELLS; k++) tape_cells[k] = 8'd0;
      dptr     = '0;
      pc_reg   = '0;
      in_rd    = '0;
      err_flag = 1'b0;
   endfunction

   // interpret one accepted request and return the status it should produce
   function automatic step_status_type interpret_request(op_type op, logic [ADDR_W-1:0] addr,
                                                         instr_type code, logic [7:0] data);
      step_status_type res;
      int len;
      int pcv;
      int nxt;
      int depth;
      int i;
      bit found;
      res = '0;
      len = (int'(prog_len) < PROGRAM_DEPTH) ? int'(prog_len) : PROGRAM_DEPTH;
      case (op)
         OP_WRITE_PROG: prog_codes[addr] = code;
         OP_PUSH: begin
            if (int'(in_count) < INPUT_DEPTH) begin
               in_bytes[in_count] = data;
               in_count = in_count + 1'b1;
            end
         end
         OP_RESTART: clear_run_state();
         default: begin
            if (!err_flag && int'(pc_reg) < len) begin
               pcv   = int'(pc_reg);
               nxt   = pcv + 1;
               depth = 0;
               found = 1'b0;
               case (prog_codes[pcv])
                  I_RIGHT: if (int'(dptr) < TAPE_CELLS - 1) dptr = dptr + 1'b1;
                  I_LEFT:  if (dptr != '0) dptr = dptr - 1'b1;
                  I_INC:   tape_cells[dptr] = tape_cells[dptr] + 8'd1;
                  I_DEC:   tape_cells[dptr] = tape_cells[dptr] - 8'd1;
                  I_OUT: begin
                     res.out_valid = 1'b1;
                     res.out_byte  = tape_cells[dptr];
                  end
                  I_IN: begin
                     // past the pushed bytes the cell reads zero
                     if (in_rd < in_count) tape_cells[dptr] = in_bytes[in_rd];
                     else tape_cells[dptr] = 8'd0;
                     if (int'(in_rd) < INPUT_DEPTH) in_rd = in_rd + 1'b1;
                  end
                  I_OPEN: begin
                     if (tape_cells[dptr] == 8'd0) begin
                        // forward scan for the partner bracket
                        for (i = pcv; i < len && !found; i++) begin
                           if (prog_codes[i] == I_OPEN) begin
                              depth++;
                           end else if (prog_codes[i] == I_CLOSE) begin
                              depth--;
                              if (depth == 0) begin
                                 nxt   = i + 1;
                                 found = 1'b1;
                              end
                           end
                        end
                        if (!found) begin
                           err_flag = 1'b1;
                           nxt      = pcv;
                        end
                     end
                  end
                  default: begin
                     if (tape_cells[dptr] != 8'd0) begin
                        // backward scan for the partner bracket
                        for (i = pcv; i >= 0 && !found; i--) begin
                           if (prog_codes[i] == I_CLOSE) begin
                              depth++;
                           end else if (prog_codes[i] == I_OPEN) begin
                              depth--;
                              if (depth == 0) begin
                                 nxt   = i + 1;
                                 found = 1'b1;
                              end
                           end
                        end
                        if (!found) begin
                           err_flag = 1'b1;
                           nxt      = pcv;
                        end
                     end
                  end
               endcase
               pc_reg = PC_W'(nxt);
            end
         end
      endcase
      res.halted        = err_flag || (int'(pc_reg) >= len);
      res.bracket_error = err_flag;
      res.pc_now        = 8'(pc_reg);
      return res;
   endfunction

   // sample every handshake at the rising edge, predict and compare
   always @(posedge clock) begin : monitor
      step_status_type want;
      if (reset) begin
         clear_run_state();
         in_count    = '0;
         prog_len    = '0;
         idle_cycles = 0;
         status_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $display("%0t: response transaction with nothing pending, pc_now %0d",
                        $time, rsp_pc_now);
               error_count++;
            end else begin
               want = status_q.pop_front();
               checked_count++;
               if (rsp_out_valid !== want.out_valid) begin
                  $display("%0t: out_valid expected %0d actual %0d",
                           $time, want.out_valid, rsp_out_valid);
                  error_count++;
               end
               if (rsp_out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %0d actual %0d",
                           $time, want.out_byte, rsp_out_byte);
                  error_count++;
               end
               if (rsp_halted !== want.halted) begin
                  $display("%0t: halted expected %0d actual %0d",
                           $time, want.halted, rsp_halted);
                  error_count++;
               end
               if (rsp_bracket_error !== want.bracket_error) begin
                  $display("%0t: bracket_error expected %0d actual %0d",
                           $time, want.bracket_error, rsp_bracket_error);
                  error_count++;
               end
               if (rsp_pc_now !== want.pc_now) begin
                  $display("%0t: pc_now expected %0d actual %0d",
                           $time, want.pc_now, rsp_pc_now);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            status_q.push_back(interpret_request(op_type'(req_opcode), req_prog_address,
                                                 instr_type'(req_instr_code), req_data_byte));
         if (csr_valid && csr_ready) prog_len = csr_data;
         // cycles with no transaction on any channel
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
      end
   end

   // watchdog on a stalled run
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // response side: random stall bursts and one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one request transaction and wait until it is taken
   task automatic send_request(input op_type op, input logic [ADDR_W-1:0] addr,
                               input logic [2:0] code, input logic [BYTE_W-1:0] data);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 15)) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_prog_address <= addr;
      req_instr_code   <= code;
      req_data_byte    <= data;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic load_code(input int addr, input instr_type code);
      send_request(OP_WRITE_PROG, ADDR_W'(addr), code, BYTE_W'($urandom));
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] data);
      send_request(OP_PUSH, ADDR_W'($urandom), 3'($urandom), data);
   endtask

   task automatic restart_run();
      send_request(OP_RESTART, ADDR_W'($urandom), 3'($urandom), BYTE_W'($urandom));
   endtask

   task automatic step_machine(input int count);
      repeat (count) send_request(OP_STEP, ADDR_W'($urandom), 3'($urandom), BYTE_W'($urandom));
   endtask

   // stop offering and wait for every pending response
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
   endtask

   // program length is only written with the machine idle
   task automatic set_program_length(input int len);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= LEN_W'(len);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random program, balanced brackets unless broken
   task automatic write_random_program(input int len, input bit well_formed);
      int depth;
      int remaining;
      int r;
      instr_type c;
      depth = 0;
      for (int i = 0; i < len; i++) begin
         remaining = len - i;
         if (!well_formed) begin
            c = instr_type'($urandom_range(0, 7));
         end else if (depth == remaining) begin
            c = I_CLOSE;
            depth--;
         end else begin
            r = $urandom_range(0, 9);
            if (r == 0 && remaining > depth + 1) begin
               c = I_OPEN;
               depth++;
            end else if (r == 1 && depth > 0) begin
               c = I_CLOSE;
               depth--;
            end else begin
               c = instr_type'($urandom_range(0, 5));
            end
         end
         load_code(i, c);
      end
   endtask

   // length zero straight after reset: every step reports halted
   task automatic test_reset_length();
      step_machine(1);
      restart_run();
      step_machine(1);
   endtask

   // every program entry gets a code before anything can execute it
   task automatic test_fill_store();
      for (int a = 0; a < PROGRAM_DEPTH; a++) load_code(a, instr_type'($urandom_range(0, 7)));
   endtask

   // pointer at cell 0, empty input, wraparound, output, forward jump, halt, bad brackets
   task automatic test_directed_cases();
      load_code(0, I_LEFT);
      load_code(1, I_IN);
      load_code(2, I_DEC);
      load_code(3, I_OUT);
      load_code(4, I_INC);
      load_code(5, I_OPEN);
      load_code(6, I_OUT);
      load_code(7, I_CLOSE);
      set_program_length(8);
      restart_run();
      step_machine(7);
      // extreme data bytes pushed, and the first read back after a restart
      push_byte(8'd0);
      push_byte(8'd255);
      restart_run();
      step_machine(2);
      // close bracket with no partner
      load_code(0, I_INC);
      load_code(1, I_CLOSE);
      restart_run();
      step_machine(3);
      // open bracket with no partner
      load_code(0, I_OPEN);
      load_code(1, I_OPEN);
      restart_run();
      step_machine(2);
   endtask

   // walk the pointer to the last cell while the response side holds off
   task automatic test_pointer_sweep();
      load_code(0, I_INC);
      load_code(1, I_OPEN);
      load_code(2, I_RIGHT);
      load_code(3, I_INC);
      load_code(4, I_CLOSE);
      set_program_length(5);
      restart_run();
      hold_pending = 1'b1;
      step_machine(210);
   endtask

   // fill the input queue past its depth and read past its end
   task automatic test_input_exhaust();
      load_code(0, I_INC);
      load_code(1, I_OPEN);
      load_code(2, I_RIGHT);
      for (int i = 3; i < 10; i++) load_code(i, I_IN);
      load_code(10, I_OUT);
      load_code(11, I_LEFT);
      load_code(12, I_CLOSE);
      set_program_length(13);
      restart_run();
      repeat (INPUT_DEPTH + 2) push_byte(BYTE_W'($urandom));
      step_machine(120);
   endtask

   // random programs with random lengths, pushes, noise and steps
   task automatic test_random_programs(input int item_budget);
      int stop_at;
      int k;
      int r;
      int len;
      int steps;
      stop_at = items_sent + item_budget;
      k = 0;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 9);
         if (k == 0) len = 255;
         else if (k == 1) len = 0;
         else if (k == 2) len = PROGRAM_DEPTH;
         else if (r == 0) len = 0;
         else if (r == 1) len = PROGRAM_DEPTH;
         else if (r == 2) len = $urandom_range(PROGRAM_DEPTH + 1, 255);
         else len = $urandom_range(1, 24);
         if (len > 0 && len <= 24) write_random_program(len, $urandom_range(0, 4) != 0);
         set_program_length(len);
         restart_run();
         repeat ($urandom_range(0, 3)) push_byte(BYTE_W'($urandom));
         if (len == 0) steps = 3;
         else if (len <= 24) steps = $urandom_range(len, 3 * len + 8);
         else steps = $urandom_range(20, 120);
         repeat (steps) begin
            if ($urandom_range(0, 15) == 0)
               send_request(op_type'($urandom_range(0, 2)), ADDR_W'($urandom),
                            3'($urandom), BYTE_W'($urandom));
            else
               step_machine(1);
         end
         k++;
      end
   endtask

   // main sequence
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_STEP;
      req_prog_address = '0;
      req_instr_code   = '0;
      req_data_byte    = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_length();
      test_fill_store();
      test_directed_cases();
      test_pointer_sweep();
      test_input_exhaust();
      test_random_programs(100);
      // closing stretch with both sides running flat out
      no_idle = 1'b1;
      test_random_programs(30);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d requests, checked %0d responses", items_sent, checked_count);
      $display("lengths 0 to 255, bracket errors, queue overflow, pointer limits, long stall");
      if (error_count == 0 && status_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
src/bft_pkg.sv
src/bft_datapath.sv
src/bft_control.sv
src/brainfuck_tape_machine.sv
tb/brainfuck_tape_machine_test.sv
